FILE: rtl/rbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared codes for the ray/box slab intersection block.
// ----------------------------------------------------------------------------
package rbs_pkg;

	// Three axes, two slab planes per axis
	localparam int NUM_AXES  = 3;
	localparam int NUM_LANES = 2 * NUM_AXES;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 3;
	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_BOX_MIN_X = 3'd0,
		CFG_BOX_MIN_Y = 3'd1,
		CFG_BOX_MIN_Z = 3'd2,
		CFG_BOX_MAX_X = 3'd3,
		CFG_BOX_MAX_Y = 3'd4,
		CFG_BOX_MAX_Z = 3'd5
	} cfg_idx_t;

endpackage

FILE: rtl/ray_box_slab_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersection
// Ray versus axis-aligned box test by the slab method, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one ray per transaction: origin x/y/z then direction
//   x/y/z, signed fixed point. m_* channel returns one result per ray, in
//   order: m_tuser holds the hit flag, m_tdata the entry distance and the
//   hit point. The box corners are written on the cfg_* channel (index 0..5:
//   min x/y/z, max x/y/z); cfg_ready is always high, writes beyond index 5
//   are dropped. Write the box only while no ray is in flight.
// Pipeline: one numerator stage, one restoring divider step per quotient bit,
//   four slab-ordering stages, a product stage and the output register. The
//   divider chain sets the depth.
// Throughput: one ray per cycle while m_tready keeps the pipe moving.
//   Every stage has its own valid bit and is ready when empty or when the
//   next stage moves; that ready ripples back through the whole pipe in the
//   same cycle, so bubbles close up.
// Reset: clears all valid bits; box resets to the unit cube [0,1]^3.
// Stall: when m_tready is low the result holds; earlier stages keep filling
//   until the pipe is full, then s_tready drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	// origin x, y, z, direction x, y, z (lowest bits first)
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]             s_tdata,
	input  logic                                           s_tvalid,
	output logic                                           s_tready,
	// distance, point x, point y, point z (lowest bits first)
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0]             m_tdata,
	// hit
	output logic [0:0]                                     m_tuser,
	output logic                                           m_tvalid,
	input  logic                                           m_tready,
	input  logic                                           cfg_valid,
	output logic                                           cfg_ready,
	input  logic [rbs_pkg::CFG_ADDR_W-1:0]                 cfg_addr,
	input  logic [COORD_WIDTH-1:0]                         cfg_data
);

	localparam int W    = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int QW   = W + F + 1;
	localparam int OTW  = ((4*COORD_WIDTH+7)/8)*8;

	logic [rbs_pkg::NUM_AXES-1:0][W-1:0] bmin_q, bmax_q;
	logic [rbs_pkg::NUM_AXES-1:0][W-1:0] in_o, in_d;

	// divider chain, one entry per step boundary
	logic [QW:0]                                   dv_valid, dv_ready;
	logic [QW:0][rbs_pkg::NUM_LANES-1:0][W-1:0]    dv_rem;
	logic [QW:0][rbs_pkg::NUM_LANES-1:0][W+F:0]    dv_nq;
	logic [QW:0][rbs_pkg::NUM_AXES-1:0][W-1:0]     dv_den;
	logic [QW:0][6*W+11:0]                         dv_side;

	logic                                sl_valid, sl_ready, sl_hit;
	logic [W-1:0]                        sl_t;
	logic [rbs_pkg::NUM_AXES-1:0][W-1:0] sl_o, sl_d;
	logic                                pt_hit;
	logic [W-1:0]                        pt_dist;
	logic [rbs_pkg::NUM_AXES-1:0][W-1:0] pt_xyz;

	// Box registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bmin_q <= '0;
			for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
				bmax_q[a] <= W'(1) << F;
			end
		end else if (cfg_valid) begin
			unique case (rbs_pkg::cfg_idx_t'(cfg_addr))
				rbs_pkg::CFG_BOX_MIN_X: bmin_q[0] <= cfg_data;
				rbs_pkg::CFG_BOX_MIN_Y: bmin_q[1] <= cfg_data;
				rbs_pkg::CFG_BOX_MIN_Z: bmin_q[2] <= cfg_data;
				rbs_pkg::CFG_BOX_MAX_X: bmax_q[0] <= cfg_data;
				rbs_pkg::CFG_BOX_MAX_Y: bmax_q[1] <= cfg_data;
				rbs_pkg::CFG_BOX_MAX_Z: bmax_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input unpacking
	always_comb begin
		for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
			in_o[a] = s_tdata[a*W +: W];
			in_d[a] = s_tdata[(3+a)*W +: W];
		end
	end

	rbs_front #(.W(W), .F(F)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.origin    (in_o),
		.dir       (in_d),
		.bmin      (bmin_q),
		.bmax      (bmax_q),
		.out_valid (dv_valid[0]),
		.out_ready (dv_ready[0]),
		.nq        (dv_nq[0]),
		.den       (dv_den[0]),
		.side      (dv_side[0])
	);

	assign dv_rem[0] = '0;

	// One quotient bit per stage
	for (genvar i = 0; i < QW; i++) begin : g_div
		rbs_div_step #(.W(W), .F(F)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_valid[i]),
			.in_ready  (dv_ready[i]),
			.rem_in    (dv_rem[i]),
			.nq_in     (dv_nq[i]),
			.den_in    (dv_den[i]),
			.side_in   (dv_side[i]),
			.out_valid (dv_valid[i+1]),
			.out_ready (dv_ready[i+1]),
			.rem_out   (dv_rem[i+1]),
			.nq_out    (dv_nq[i+1]),
			.den_out   (dv_den[i+1]),
			.side_out  (dv_side[i+1])
		);
	end

	rbs_slab #(.W(W), .F(F)) u_slab (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid[QW]),
		.in_ready  (dv_ready[QW]),
		.nq_in     (dv_nq[QW]),
		.side_in   (dv_side[QW]),
		.out_valid (sl_valid),
		.out_ready (sl_ready),
		.hit       (sl_hit),
		.tdist     (sl_t),
		.origin    (sl_o),
		.dir       (sl_d)
	);

	rbs_point #(.W(W), .F(F)) u_point (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sl_valid),
		.in_ready  (sl_ready),
		.hit       (sl_hit),
		.tdist     (sl_t),
		.origin    (sl_o),
		.dir       (sl_d),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.hit_out   (pt_hit),
		.dist_out  (pt_dist),
		.point_out (pt_xyz)
	);

	assign m_tuser = pt_hit;
	assign m_tdata = OTW'({pt_xyz, pt_dist});

endmodule

FILE: rtl/rbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_front
// First stage: slab numerators (corner - origin), their magnitudes and signs,
// and the direction magnitudes that the divider lanes work with.
// ----------------------------------------------------------------------------
module rbs_front #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  origin,
	input  logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  dir,
	input  logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  bmin,
	input  logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  bmax,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rbs_pkg::NUM_LANES-1:0][W+F:0] nq,
	output logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  den,
	output logic [6*W+11:0]                      side
);

	logic                                 valid_s1;
	logic [rbs_pkg::NUM_LANES-1:0][W:0]   num;
	logic [rbs_pkg::NUM_LANES-1:0][W:0]   nmag;
	logic [rbs_pkg::NUM_LANES-1:0]        nneg;
	logic [rbs_pkg::NUM_LANES-1:0]        nnz;
	logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  dmag;

	// Numerators one bit wider than a coordinate so they never wrap
	always_comb begin
		for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
			num[2*a]   = {bmin[a][W-1], bmin[a]} - {origin[a][W-1], origin[a]};
			num[2*a+1] = {bmax[a][W-1], bmax[a]} - {origin[a][W-1], origin[a]};
			dmag[a]    = dir[a][W-1] ? (~dir[a] + 1'b1) : dir[a];
		end
		for (int l = 0; l < rbs_pkg::NUM_LANES; l++) begin
			nneg[l] = num[l][W];
			nnz[l]  = |num[l];
			nmag[l] = num[l][W] ? (~num[l] + 1'b1) : num[l];
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Dividend is the numerator magnitude scaled by 2^F
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int l = 0; l < rbs_pkg::NUM_LANES; l++) begin
				nq[l] <= {nmag[l], {F{1'b0}}};
			end
			den  <= dmag;
			side <= {nnz, nneg, dir, origin};
		end
	end

endmodule

FILE: rtl/rbs_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_div_step
// One restoring division step for all six slab lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module rbs_div_step #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rbs_pkg::NUM_LANES-1:0][W-1:0] rem_in,
	input  logic [rbs_pkg::NUM_LANES-1:0][W+F:0] nq_in,
	input  logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  den_in,
	input  logic [6*W+11:0]                      side_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rbs_pkg::NUM_LANES-1:0][W-1:0] rem_out,
	output logic [rbs_pkg::NUM_LANES-1:0][W+F:0] nq_out,
	output logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  den_out,
	output logic [6*W+11:0]                      side_out
);

	logic                                 valid_q;
	logic [rbs_pkg::NUM_LANES-1:0][W:0]   shifted;
	logic [rbs_pkg::NUM_LANES-1:0][W+1:0] diff;
	logic [rbs_pkg::NUM_LANES-1:0][W-1:0] rem_nx;
	logic [rbs_pkg::NUM_LANES-1:0][W+F:0] nq_nx;

	// Trial subtract; keep it when it does not borrow
	always_comb begin
		for (int l = 0; l < rbs_pkg::NUM_LANES; l++) begin
			shifted[l] = {rem_in[l], nq_in[l][W+F]};
			diff[l]    = {1'b0, shifted[l]} - {2'b00, den_in[l/2]};
			if (!diff[l][W+1]) begin
				rem_nx[l] = diff[l][W-1:0];
			end else begin
				rem_nx[l] = shifted[l][W-1:0];
			end
			nq_nx[l] = {nq_in[l][W+F-1:0], !diff[l][W+1]};
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_out  <= rem_nx;
			nq_out   <= nq_nx;
			den_out  <= den_in;
			side_out <= side_in;
		end
	end

endmodule

FILE: rtl/rbs_slab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_slab
// Quotient saturation, per-axis entry/exit ordering, and the x/y then z
// interval overlap tests. Four register stages.
// ----------------------------------------------------------------------------
module rbs_slab #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rbs_pkg::NUM_LANES-1:0][W+F:0] nq_in,
	input  logic [6*W+11:0]                      side_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hit,
	output logic [W-1:0]                         tdist,
	output logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  origin,
	output logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  dir
);

	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  o_in, d_in;
	logic [rbs_pkg::NUM_LANES-1:0]        nneg, nnz;
	logic [rbs_pkg::NUM_LANES-1:0][W-1:0] tq;

	// stage registers
	logic                                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                                 rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic [rbs_pkg::NUM_LANES-1:0][W-1:0] t_s1;
	logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  lo_s2, hi_s2;
	logic [W-1:0]                         tmin_s3, tmax_s3, zlo_s3, zhi_s3;
	logic                                 ok_s3;
	logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  o_s1, o_s2, o_s3, o_s4;
	logic [rbs_pkg::NUM_AXES-1:0][W-1:0]  d_s1, d_s2, d_s3, d_s4;
	logic                                 hit_s4;
	logic [W-1:0]                         t_s4;

	always_comb begin
		for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
			o_in[a] = side_in[a*W +: W];
			d_in[a] = side_in[(3+a)*W +: W];
		end
		nneg = side_in[6*W +: 6];
		nnz  = side_in[6*W+6 +: 6];
	end

	// Quotient sign and saturation; zero divisor saturates by numerator sign
	always_comb begin
		for (int l = 0; l < rbs_pkg::NUM_LANES; l++) begin
			if (d_in[l/2] == '0) begin
				tq[l] = nneg[l] ? VMIN : (nnz[l] ? VMAX : '0);
			end else if (nneg[l] == d_in[l/2][W-1]) begin
				tq[l] = (|nq_in[l][W+F:W-1]) ? VMAX : nq_in[l][W-1:0];
			end else if ((|nq_in[l][W+F:W]) ||
				(nq_in[l][W-1] && (|nq_in[l][W-2:0]))) begin
				tq[l] = VMIN;
			end else begin
				tq[l] = ~nq_in[l][W-1:0] + 1'b1;
			end
		end
	end

	// ready chain, back to front
	assign rdy_s4    = !valid_s4 || out_ready;
	assign rdy_s3    = !valid_s3 || rdy_s4;
	assign rdy_s2    = !valid_s2 || rdy_s3;
	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: saturated distances
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			t_s1 <= tq;
			o_s1 <= o_in;
			d_s1 <= d_in;
		end
	end

	// stage 2: order each axis pair as entry/exit
	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
				if ($signed(t_s1[2*a]) > $signed(t_s1[2*a+1])) begin
					lo_s2[a] <= t_s1[2*a+1];
					hi_s2[a] <= t_s1[2*a];
				end else begin
					lo_s2[a] <= t_s1[2*a];
					hi_s2[a] <= t_s1[2*a+1];
				end
			end
			o_s2 <= o_s1;
			d_s2 <= d_s1;
		end
	end

	// stage 3: x/y overlap and merge
	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			ok_s3   <= !(($signed(lo_s2[0]) > $signed(hi_s2[1])) ||
				($signed(lo_s2[1]) > $signed(hi_s2[0])));
			tmin_s3 <= ($signed(lo_s2[1]) > $signed(lo_s2[0])) ? lo_s2[1] : lo_s2[0];
			tmax_s3 <= ($signed(hi_s2[1]) < $signed(hi_s2[0])) ? hi_s2[1] : hi_s2[0];
			zlo_s3  <= lo_s2[2];
			zhi_s3  <= hi_s2[2];
			o_s3    <= o_s2;
			d_s3    <= d_s2;
		end
	end

	// stage 4: z test against the merged interval
	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			hit_s4 <= ok_s3 && !(($signed(tmin_s3) > $signed(zhi_s3)) ||
				($signed(zlo_s3) > $signed(tmax_s3)));
			t_s4   <= ($signed(zlo_s3) > $signed(tmin_s3)) ? zlo_s3 : tmin_s3;
			o_s4   <= o_s3;
			d_s4   <= d_s3;
		end
	end

	assign hit    = hit_s4;
	assign tdist  = t_s4;
	assign origin = o_s4;
	assign dir    = d_s4;

endmodule

FILE: rtl/rbs_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_point
// Hit point origin + t*dir: product stage, then floor shift, add, saturate
// into the output register.
// ----------------------------------------------------------------------------
module rbs_point #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                hit,
	input  logic [W-1:0]                        tdist,
	input  logic [rbs_pkg::NUM_AXES-1:0][W-1:0] origin,
	input  logic [rbs_pkg::NUM_AXES-1:0][W-1:0] dir,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit_out,
	output logic [W-1:0]                        dist_out,
	output logic [rbs_pkg::NUM_AXES-1:0][W-1:0] point_out
);

	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	logic                                  valid_s1, valid_s2, rdy_s1, rdy_s2;
	logic                                  hit_s1;
	logic [W-1:0]                          t_s1;
	logic [rbs_pkg::NUM_AXES-1:0][W-1:0]   o_s1;
	logic [rbs_pkg::NUM_AXES-1:0][2*W-1:0] p_s1;
	logic [rbs_pkg::NUM_AXES-1:0][2*W-1:0] sh;
	logic [rbs_pkg::NUM_AXES-1:0][2*W:0]   sum;
	logic [rbs_pkg::NUM_AXES-1:0][W-1:0]   pt;

	assign rdy_s2    = !valid_s2 || out_ready;
	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
		end
	end

	// stage 1: exact products
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
				p_s1[a] <= (2*W)'($signed(tdist) * $signed(dir[a]));
			end
			hit_s1 <= hit;
			t_s1   <= tdist;
			o_s1   <= origin;
		end
	end

	// arithmetic shift floors; sum saturates to the coordinate range
	always_comb begin
		for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
			sh[a]  = $signed(p_s1[a]) >>> F;
			sum[a] = {{(W+1){o_s1[a][W-1]}}, o_s1[a]} + {sh[a][2*W-1], sh[a]};
			if ((&sum[a][2*W:W-1]) || !(|sum[a][2*W:W-1])) begin
				pt[a] = sum[a][W-1:0];
			end else begin
				pt[a] = sum[a][2*W] ? VMIN : VMAX;
			end
		end
	end

	// stage 2: output register; a miss reports far distance and zero point
	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			hit_out <= hit_s1;
			if (hit_s1) begin
				dist_out  <= t_s1;
				point_out <= pt;
			end else begin
				dist_out  <= VMAX;
				point_out <= '0;
			end
		end
	end

endmodule

FILE: rtl/rbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_checker
// Port-level checks for the slab intersection block, bound to the top level.
// ----------------------------------------------------------------------------
module rbs_checker #(
	parameter int COORD_WIDTH = 32
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_tready,
	input logic [((4*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
	input logic [0:0]                            m_tuser,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic                                  cfg_ready
);

	localparam int W = COORD_WIDTH;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A miss reports far distance and a zero point
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |->
			m_tdata[W-1:0] == {1'b0, {(W-1){1'b1}}} && m_tdata[4*W-1:W] == '0)
		else $error("miss result fields wrong");

	// An empty output register means the whole pipe can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// Nothing emerges the cycle after reset releases
	a_rst: assert property (@(posedge clk)
		!$past(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

	// Configuration never back-pressures
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind ray_box_slab_intersection rbs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.cfg_ready (cfg_ready)
);
